>>> rtl/zctm_pkg.sv
// Package for the zero-crossing tuner meter: widths, constants, codes and the
// command/status structs between controller and datapath.
// No dependencies.
package zctm_pkg;

	localparam int SAMPLE_W = 12;
	localparam int TIME_W   = 24;
	localparam int FREQ_W   = 34;
	localparam int CFG_W    = 20;
	localparam int IDX_W    = 3;
	localparam int OFS_W    = 12;
	localparam int THR_W    = 11;
	localparam int CNT_W    = $clog2(FREQ_W);

	// timer clock and the dividend of the frequency division (centihertz)
	localparam logic [63:0] CLOCK_HZ = 64'd100000000;
	localparam logic [FREQ_W-1:0] DIVIDEND = FREQ_W'(CLOCK_HZ * 64'd100);

	// register indexes
	localparam logic [IDX_W-1:0] REG_OFFSET    = 3'd0;
	localparam logic [IDX_W-1:0] REG_NOISE_THR = 3'd1;
	localparam logic [IDX_W-1:0] REG_TARGET    = 3'd2;
	localparam logic [IDX_W-1:0] REG_TOLERANCE = 3'd3;
	localparam logic [IDX_W-1:0] REG_MIN       = 3'd4;
	localparam logic [IDX_W-1:0] REG_MAX       = 3'd5;

	// register reset values
	localparam logic [OFS_W-1:0] RST_OFFSET    = 12'd1800;
	localparam logic [THR_W-1:0] RST_NOISE_THR = 11'd8;
	localparam logic [CFG_W-1:0] RST_TARGET    = 20'd8241;
	localparam logic [CFG_W-1:0] RST_TOLERANCE = 20'd100;
	localparam logic [CFG_W-1:0] RST_MIN       = 20'd6000;
	localparam logic [CFG_W-1:0] RST_MAX       = 20'd15000;

	// verdict codes
	localparam logic [1:0] V_IN_TUNE = 2'd0;
	localparam logic [1:0] V_TIGHTEN = 2'd1;
	localparam logic [1:0] V_LOOSEN  = 2'd2;
	localparam logic [1:0] V_RANGE   = 2'd3;

	typedef struct packed {
		logic accept;
		logic div_step;
		logic eval;
		logic load;
	} cmd_t;

	typedef struct packed {
		logic close;
		logic div_last;
		logic out_free;
		logic armed;
	} sts_t;

endpackage

>>> rtl/zctm_in_if.sv
// Sample channel: valid/ready handshake with sample and timestamp payload.
// Depends on zctm_pkg.
interface zctm_in_if;
	logic                            valid;
	logic                            ready;
	logic [zctm_pkg::SAMPLE_W-1:0]   sample;
	logic [zctm_pkg::TIME_W-1:0]     timestamp;

	modport source (output valid, output sample, output timestamp, input ready);
	modport sink   (input valid, input sample, input timestamp, output ready);
endinterface

>>> rtl/zctm_out_if.sv
// Result channel: valid/ready handshake with period, frequency and verdict.
// Depends on zctm_pkg.
interface zctm_out_if;
	logic                          valid;
	logic                          ready;
	logic [zctm_pkg::TIME_W-1:0]   period_ticks;
	logic [zctm_pkg::FREQ_W-1:0]   freq_centihz;
	logic [1:0]                    verdict;
	logic [zctm_pkg::FREQ_W-1:0]   deviation_centihz;

	modport source (output valid, output period_ticks, output freq_centihz,
		output verdict, output deviation_centihz, input ready);
	modport sink   (input valid, input period_ticks, input freq_centihz,
		input verdict, input deviation_centihz, output ready);
endinterface

>>> rtl/zctm_ctrl.sv
// Controller for the tuner meter: sequences sample intake, the bit-serial
// division, the verdict stage and the output load. Depends on zctm_pkg.
module zctm_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  zctm_pkg::sts_t   sts,
	output zctm_pkg::cmd_t   cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_DIV  = 2'd1;
	localparam logic [1:0] S_EVAL = 2'd2;
	localparam logic [1:0] S_OUT  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nx;

	assign in_ready = (state_q == S_IDLE);

	// next state and commands
	always_comb begin
		state_nx     = state_q;
		cmd.accept   = 1'b0;
		cmd.div_step = 1'b0;
		cmd.eval     = 1'b0;
		cmd.load     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				cmd.accept = in_valid;
				if (in_valid && sts.close)
					state_nx = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last)
					state_nx = S_EVAL;
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				state_nx = S_OUT;
			end
			S_OUT: begin
				if (sts.out_free) begin
					cmd.load = 1'b1;
					state_nx = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_nx;
	end

endmodule

>>> rtl/zctm_dp.sv
// Datapath for the tuner meter: config registers, crossing detector,
// restoring divider, verdict logic and output register. Depends on zctm_pkg.
module zctm_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [zctm_pkg::IDX_W-1:0]      wr_index,
	input  logic [zctm_pkg::CFG_W-1:0]      wr_data,
	input  logic [zctm_pkg::SAMPLE_W-1:0]   sample,
	input  logic [zctm_pkg::TIME_W-1:0]     timestamp,
	input  zctm_pkg::cmd_t                  cmd,
	output zctm_pkg::sts_t                  sts,
	input  logic                            out_ready,
	output logic                            out_valid,
	output logic [zctm_pkg::TIME_W-1:0]     period_ticks,
	output logic [zctm_pkg::FREQ_W-1:0]     freq_centihz,
	output logic [1:0]                      verdict,
	output logic [zctm_pkg::FREQ_W-1:0]     deviation_centihz
);

	localparam int FW = zctm_pkg::FREQ_W;
	localparam int TW = zctm_pkg::TIME_W;
	localparam int SW = zctm_pkg::SAMPLE_W;

	// configuration registers
	logic [zctm_pkg::OFS_W-1:0] offset_q;
	logic [zctm_pkg::THR_W-1:0] noise_thr_q;
	logic [zctm_pkg::CFG_W-1:0] target_q;
	logic [zctm_pkg::CFG_W-1:0] tolerance_q;
	logic [zctm_pkg::CFG_W-1:0] min_q;
	logic [zctm_pkg::CFG_W-1:0] max_q;

	// crossing state
	logic [SW-1:0] prev_q;
	logic          armed_q;
	logic [TW-1:0] start_q;

	// divider and evaluation
	logic [TW-1:0]                 period_q;
	logic [TW-1:0]                 rem_q;
	logic [FW-1:0]                 quo_q;
	logic [zctm_pkg::CNT_W-1:0]    cnt_q;
	logic [FW-1:0]                 dev_q;
	logic                          in_range_q;
	logic                          below_q;

	// output register
	logic          out_valid_q;
	logic [TW-1:0] out_period_q;
	logic [FW-1:0] out_freq_q;
	logic [1:0]    out_verdict_q;
	logic [FW-1:0] out_dev_q;

	logic signed [SW:0] p_c;
	logic signed [SW:0] c_c;
	logic [SW-1:0]      mag_p;
	logic [SW-1:0]      mag_c;
	logic               noise;
	logic               rising;
	logic [TW-1:0]      period_c;
	logic [TW:0]        r_shift;
	logic [TW:0]        trial;
	logic [FW-1:0]      tgt_w;
	logic               ge;
	logic [1:0]         verdict_c;

	// config writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q    <= zctm_pkg::RST_OFFSET;
			noise_thr_q <= zctm_pkg::RST_NOISE_THR;
			target_q    <= zctm_pkg::RST_TARGET;
			tolerance_q <= zctm_pkg::RST_TOLERANCE;
			min_q       <= zctm_pkg::RST_MIN;
			max_q       <= zctm_pkg::RST_MAX;
		end else if (wr_en) begin
			unique case (wr_index)
				zctm_pkg::REG_OFFSET:    offset_q    <= wr_data[zctm_pkg::OFS_W-1:0];
				zctm_pkg::REG_NOISE_THR: noise_thr_q <= wr_data[zctm_pkg::THR_W-1:0];
				zctm_pkg::REG_TARGET:    target_q    <= wr_data;
				zctm_pkg::REG_TOLERANCE: tolerance_q <= wr_data;
				zctm_pkg::REG_MIN:       min_q       <= wr_data;
				zctm_pkg::REG_MAX:       max_q       <= wr_data;
				default: ;
			endcase
		end
	end

	// centre both samples and look for a rising crossing outside the noise band
	always_comb begin
		p_c      = $signed({1'b0, prev_q}) - $signed({1'b0, offset_q});
		c_c      = $signed({1'b0, sample}) - $signed({1'b0, offset_q});
		mag_p    = p_c[SW] ? SW'(-p_c) : p_c[SW-1:0];
		mag_c    = c_c[SW] ? SW'(-c_c) : c_c[SW-1:0];
		noise    = (mag_p <= {1'b0, noise_thr_q}) && (mag_c <= {1'b0, noise_thr_q});
		rising   = !noise && (p_c[SW] || (p_c == '0)) && !c_c[SW] && (c_c != '0);
		period_c = start_q - timestamp;
	end

	assign sts.close    = rising && armed_q && (period_c != '0);
	assign sts.div_last = (cnt_q == '0);
	assign sts.out_free = !out_valid_q || out_ready;
	assign sts.armed    = armed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= '0;
			armed_q <= 1'b0;
			start_q <= '0;
		end else if (cmd.accept) begin
			prev_q <= sample;
			if (rising) begin
				armed_q <= !armed_q;
				if (!armed_q)
					start_q <= timestamp;
			end
		end
	end

	// restoring division, one quotient bit a cycle, MSB first
	always_comb begin
		r_shift = {rem_q, quo_q[FW-1]};
		trial   = r_shift - {1'b0, period_q};
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && sts.close) begin
			period_q <= period_c;
			rem_q    <= '0;
			quo_q    <= zctm_pkg::DIVIDEND;
			cnt_q    <= zctm_pkg::CNT_W'(FW - 1);
		end else if (cmd.div_step) begin
			rem_q <= trial[TW] ? r_shift[TW-1:0] : trial[TW-1:0];
			quo_q <= {quo_q[FW-2:0], !trial[TW]};
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// deviation and range flags
	always_comb begin
		tgt_w = FW'(target_q);
		ge    = (quo_q >= tgt_w);
	end

	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			dev_q      <= ge ? (quo_q - tgt_w) : (tgt_w - quo_q);
			in_range_q <= (quo_q > FW'(min_q)) && (quo_q < FW'(max_q));
			below_q    <= !ge;
		end
	end

	always_comb begin
		if (!in_range_q)
			verdict_c = zctm_pkg::V_RANGE;
		else if (dev_q <= FW'(tolerance_q))
			verdict_c = zctm_pkg::V_IN_TUNE;
		else if (below_q)
			verdict_c = zctm_pkg::V_TIGHTEN;
		else
			verdict_c = zctm_pkg::V_LOOSEN;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_period_q  <= period_q;
			out_freq_q    <= quo_q;
			out_verdict_q <= verdict_c;
			out_dev_q     <= dev_q;
		end
	end

	assign out_valid         = out_valid_q;
	assign period_ticks      = out_period_q;
	assign freq_centihz      = out_freq_q;
	assign verdict           = out_verdict_q;
	assign deviation_centihz = out_dev_q;

endmodule

>>> rtl/zero_crossing_tuner_meter_core.sv
// Tuner meter: centres each ADC sample by the offset register, finds rising
// zero crossings outside the noise band, and on every second crossing reports
// the period in timer ticks, the frequency in centihertz, a tuning verdict and
// the deviation from target. A sample that closes no period leaves the block
// ready for the next. A sample that closes a period occupies the block while
// it is taken, the bit-serial restoring divider runs (one quotient bit per
// cycle), the deviation is formed and the output register is loaded; that
// last step waits while an earlier result is still not taken. The next
// sample is accepted as soon as the result sits in the output register.
// Depends on zctm_pkg, zctm_in_if, zctm_out_if, zctm_ctrl and zctm_dp.
module zero_crossing_tuner_meter_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [zctm_pkg::IDX_W-1:0]    wr_index,
	input  logic [zctm_pkg::CFG_W-1:0]    wr_data,
	zctm_in_if.sink                       samples,
	zctm_out_if.source                    results
);

	zctm_pkg::cmd_t cmd;
	zctm_pkg::sts_t sts;
	logic           ready;

	assign samples.ready = ready;

	zctm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (samples.valid),
		.in_ready (ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	zctm_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.wr_en             (wr_en),
		.wr_index          (wr_index),
		.wr_data           (wr_data),
		.sample            (samples.sample),
		.timestamp         (samples.timestamp),
		.cmd               (cmd),
		.sts               (sts),
		.out_ready         (results.ready),
		.out_valid         (results.valid),
		.period_ticks      (results.period_ticks),
		.freq_centihz      (results.freq_centihz),
		.verdict           (results.verdict),
		.deviation_centihz (results.deviation_centihz)
	);

`ifndef ASSERT_OFF
	// closing a period always disarms the detector
	a_close_disarms: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept && sts.close |=> !sts.armed)
		else $error("detector still armed after a period closed");

	// no sample is taken while the divider runs
	a_busy_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> !samples.ready)
		else $error("sample channel ready during division");

	// a reported period is never zero
	a_period_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> (results.period_ticks != '0))
		else $error("zero period reported");
`endif

endmodule

>>> bench/tb.sv
// Testbench for zero_crossing_tuner_meter_core: a directed table, then paced random phases.
// Results are checked against an in-bench period and verdict predictor.
// Depends on zctm_pkg, zctm_in_if, zctm_out_if and the core RTL.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	// 100 MHz timer, frequencies in centihertz
	localparam longint CENTI_DIVIDEND = 64'd10_000_000_000;
	localparam longint FREQ_SAT       = (64'd1 << zctm_pkg::FREQ_W) - 64'd1;
	localparam longint TIME_MAX       = (64'd1 << zctm_pkg::TIME_W) - 64'd1;

	// indexes with no register behind them
	localparam logic [zctm_pkg::IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [zctm_pkg::IDX_W-1:0] REG_SPARE_HI = 3'd7;

	localparam int LATENCY_CYC    = 40;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int PHASE_ITEMS    = 144;
	localparam int N_PHASES       = 8;

	typedef struct packed {
		logic [zctm_pkg::TIME_W-1:0] period;
		logic [zctm_pkg::FREQ_W-1:0] freq;
		logic [1:0]                  verdict;
		logic [zctm_pkg::FREQ_W-1:0] dev;
	} meas_t;

	// how a table row gets its expectation
	typedef enum logic [1:0] {EXP_PREDICT, EXP_NONE, EXP_GIVEN} row_kind_t;

	typedef struct {
		logic [zctm_pkg::SAMPLE_W-1:0] smp;
		logic [zctm_pkg::TIME_W-1:0]   ts;
		row_kind_t                     kind;
		meas_t                         meas;
	} dir_row_t;

	logic                       clk;
	logic                       arst_n;
	logic                       wr_en;
	logic [zctm_pkg::IDX_W-1:0] wr_index;
	logic [zctm_pkg::CFG_W-1:0] wr_data;

	zctm_in_if  smp_if();
	zctm_out_if meas_if();

	zero_crossing_tuner_meter_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.samples  (smp_if),
		.results  (meas_if)
	);

	// predictor copy of the registers and the crossing state
	logic [zctm_pkg::OFS_W-1:0]    m_offset;
	logic [zctm_pkg::THR_W-1:0]    m_thr;
	logic [zctm_pkg::CFG_W-1:0]    m_target;
	logic [zctm_pkg::CFG_W-1:0]    m_tol;
	logic [zctm_pkg::CFG_W-1:0]    m_min;
	logic [zctm_pkg::CFG_W-1:0]    m_max;
	logic [zctm_pkg::SAMPLE_W-1:0] m_prev;
	logic                          m_armed;
	logic [zctm_pkg::TIME_W-1:0]   m_start;

	meas_t    pending_meas[$];
	dir_row_t dir_rows[$];

	int n_mismatch = 0;
	int n_checked  = 0;
	int n_accepted = 0;
	int gap_pct    = 0;
	int stall_pct  = 0;
	int quiet_cyc  = 0;

	// waveform shaping for the random part
	bit                          wave_hi   = 1'b0;
	bit                          first_hi  = 1'b0;
	int                          half_left = 0;
	logic [zctm_pkg::TIME_W-1:0] cross_ts  = '1;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// register write as the block applies it: masked, spare indexes dropped
	function automatic void set_reg(input logic [zctm_pkg::IDX_W-1:0] idx,
			input logic [zctm_pkg::CFG_W-1:0] val);
		case (idx)
			zctm_pkg::REG_OFFSET:    m_offset = val[zctm_pkg::OFS_W-1:0];
			zctm_pkg::REG_NOISE_THR: m_thr    = val[zctm_pkg::THR_W-1:0];
			zctm_pkg::REG_TARGET:    m_target = val;
			zctm_pkg::REG_TOLERANCE: m_tol    = val;
			zctm_pkg::REG_MIN:       m_min    = val;
			zctm_pkg::REG_MAX:       m_max    = val;
			default: ;
		endcase
	endfunction

	// one sample through the crossing detector; returns 1 when a period closes
	function automatic bit predict_meas(input logic [zctm_pkg::SAMPLE_W-1:0] smp,
			input logic [zctm_pkg::TIME_W-1:0] ts, output meas_t m);
		longint                      p, c, thr, f, tgt, d;
		logic [zctm_pkg::TIME_W-1:0] per;
		bit                          rise;
		m   = '0;
		p   = longint'(m_prev) - longint'(m_offset);
		c   = longint'(smp) - longint'(m_offset);
		thr = longint'(m_thr);
		// both inside the noise band never counts
		rise = !(((p < 0) ? -p : p) <= thr && ((c < 0) ? -c : c) <= thr) && p <= 0 && c > 0;
		m_prev = smp;
		if (!rise)
			return 1'b0;
		if (!m_armed) begin
			m_armed = 1'b1;
			m_start = ts;
			return 1'b0;
		end
		m_armed = 1'b0;
		per = m_start - ts;
		if (per == '0)
			return 1'b0;
		f = CENTI_DIVIDEND / longint'(per);
		if (f > FREQ_SAT)
			f = FREQ_SAT;
		tgt = longint'(m_target);
		d = (f >= tgt) ? f - tgt : tgt - f;
		m.period = per;
		m.freq   = f[zctm_pkg::FREQ_W-1:0];
		m.dev    = d[zctm_pkg::FREQ_W-1:0];
		if (!(f > longint'(m_min) && f < longint'(m_max)))
			m.verdict = zctm_pkg::V_RANGE;
		else if (d <= longint'(m_tol))
			m.verdict = zctm_pkg::V_IN_TUNE;
		else if (f < tgt)
			m.verdict = zctm_pkg::V_TIGHTEN;
		else
			m.verdict = zctm_pkg::V_LOOSEN;
		return 1'b1;
	endfunction

	function automatic void add_row(input logic [zctm_pkg::SAMPLE_W-1:0] smp,
			input logic [zctm_pkg::TIME_W-1:0] ts, input row_kind_t kind, input meas_t m);
		dir_rows.push_back('{smp, ts, kind, m});
	endfunction

	function automatic void check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			n_mismatch++;
			$display("%0t ns: %s mismatch: expected %0d, got %0d", $time, name, want, got);
		end
	endfunction

	task automatic write_reg(input logic [zctm_pkg::IDX_W-1:0] idx,
			input logic [zctm_pkg::CFG_W-1:0] val);
		@(negedge clk);
		wr_en    = 1'b1;
		wr_index = idx;
		wr_data  = val;
		@(negedge clk);
		wr_en = 1'b0;
		set_reg(idx, val);
	endtask

	// offer one item, with random gaps ahead of it; predict once it is taken
	task automatic send_sample(input logic [zctm_pkg::SAMPLE_W-1:0] smp,
			input logic [zctm_pkg::TIME_W-1:0] ts, input row_kind_t kind, input meas_t given);
		meas_t m;
		bit    hit;
		@(negedge clk);
		while (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
			smp_if.valid = 1'b0;
			@(negedge clk);
		end
		smp_if.valid     = 1'b1;
		smp_if.sample    = smp;
		smp_if.timestamp = ts;
		@(posedge clk);
		while (!smp_if.ready)
			@(posedge clk);
		hit = predict_meas(smp, ts, m);
		if (kind == EXP_GIVEN)
			pending_meas.push_back(given);
		else if (kind == EXP_PREDICT && hit)
			pending_meas.push_back(m);
		n_accepted++;
	endtask

	// sender holds off until every result is out and the divider has gone quiet
	task automatic hold_off();
		@(negedge clk);
		smp_if.valid = 1'b0;
		while (pending_meas.size() != 0)
			@(posedge clk);
		repeat (LATENCY_CYC) @(posedge clk);
	endtask

	task automatic load_settings(input int set_no);
		logic [zctm_pkg::CFG_W-1:0] tgt;
		logic [zctm_pkg::CFG_W-1:0] mn;
		logic [zctm_pkg::CFG_W-1:0] mx;
		case (set_no)
			0: begin
				write_reg(zctm_pkg::REG_OFFSET, zctm_pkg::CFG_W'(zctm_pkg::RST_OFFSET));
				write_reg(zctm_pkg::REG_NOISE_THR, zctm_pkg::CFG_W'(zctm_pkg::RST_NOISE_THR));
				write_reg(zctm_pkg::REG_TARGET, zctm_pkg::RST_TARGET);
				write_reg(zctm_pkg::REG_TOLERANCE, zctm_pkg::RST_TOLERANCE);
				write_reg(zctm_pkg::REG_MIN, zctm_pkg::RST_MIN);
				write_reg(zctm_pkg::REG_MAX, zctm_pkg::RST_MAX);
			end
			2: begin
				// low extremes; upper data bits must be masked off, spare indexes dropped
				write_reg(zctm_pkg::REG_OFFSET, 20'h5A000);
				write_reg(zctm_pkg::REG_NOISE_THR, 20'hFF800);
				write_reg(zctm_pkg::REG_TARGET, '0);
				write_reg(zctm_pkg::REG_TOLERANCE, '0);
				write_reg(zctm_pkg::REG_MIN, '0);
				write_reg(zctm_pkg::REG_MAX, 20'd1000000);
				write_reg(REG_SPARE_LO, 20'hFFFFF);
				write_reg(REG_SPARE_HI, 20'h00001);
			end
			4: begin
				// high extremes; min above max puts everything out of range
				write_reg(zctm_pkg::REG_OFFSET, 20'd2048);
				write_reg(zctm_pkg::REG_NOISE_THR, 20'd2047);
				write_reg(zctm_pkg::REG_TARGET, 20'd1000000);
				write_reg(zctm_pkg::REG_TOLERANCE, 20'd1000000);
				write_reg(zctm_pkg::REG_MIN, 20'd1000000);
				write_reg(zctm_pkg::REG_MAX, '0);
			end
			default: begin
				tgt = zctm_pkg::CFG_W'($urandom_range(4000, 120000));
				mn  = tgt - zctm_pkg::CFG_W'($urandom_range(0, tgt - 1));
				mx  = tgt + zctm_pkg::CFG_W'($urandom_range(1, 50000));
				// offset at full scale leaves no room above the resting level
				write_reg(zctm_pkg::REG_OFFSET, (set_no == 6) ? 20'd4095
					: zctm_pkg::CFG_W'($urandom_range(1024, 3072)));
				write_reg(zctm_pkg::REG_NOISE_THR, zctm_pkg::CFG_W'($urandom_range(0, 64)));
				write_reg(zctm_pkg::REG_TARGET, tgt);
				write_reg(zctm_pkg::REG_TOLERANCE, zctm_pkg::CFG_W'($urandom_range(0, 3000)));
				write_reg(zctm_pkg::REG_MIN, mn);
				write_reg(zctm_pkg::REG_MAX, mx);
			end
		endcase
	endtask

	// receiver pacing
	always @(negedge clk) begin
		meas_if.ready = (stall_pct == 0) || ($urandom_range(1, 100) > stall_pct);
	end

	// result checker
	always @(posedge clk) begin : result_check
		meas_t want;
		if (arst_n && meas_if.valid && meas_if.ready) begin
			if (pending_meas.size() == 0) begin
				n_mismatch++;
				$display("%0t ns: result with none expected: period %0d freq %0d verdict %0d dev %0d",
					$time, meas_if.period_ticks, meas_if.freq_centihz, meas_if.verdict,
					meas_if.deviation_centihz);
			end else begin
				want = pending_meas.pop_front();
				n_checked++;
				check_field("period_ticks", want.period, meas_if.period_ticks);
				check_field("freq_centihz", want.freq, meas_if.freq_centihz);
				check_field("verdict", want.verdict, meas_if.verdict);
				check_field("deviation_centihz", want.dev, meas_if.deviation_centihz);
			end
		end
	end

	// watchdog on cycles with no item moving on either channel
	always @(posedge clk) begin
		if ((smp_if.valid && smp_if.ready) || (meas_if.valid && meas_if.ready)) begin
			quiet_cyc = 0;
		end else begin
			quiet_cyc++;
			if (quiet_cyc >= WATCHDOG_LIMIT) begin
				$display("%0t ns: watchdog, nothing moved for %0d cycles, %0d results outstanding",
					$time, quiet_cyc, pending_meas.size());
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	initial begin : stimulus
		logic [zctm_pkg::SAMPLE_W-1:0] smp_v;
		logic [zctm_pkg::TIME_W-1:0]   ts_v;
		longint                        lo_b, span, fg, per;
		int                            pick;

		$timeformat(-9, 0, "", 0);
		arst_n           = 1'b0;
		wr_en            = 1'b0;
		wr_index         = '0;
		wr_data          = '0;
		smp_if.valid     = 1'b0;
		smp_if.sample    = '0;
		smp_if.timestamp = '0;

		m_offset = zctm_pkg::RST_OFFSET;
		m_thr    = zctm_pkg::RST_NOISE_THR;
		m_target = zctm_pkg::RST_TARGET;
		m_tol    = zctm_pkg::RST_TOLERANCE;
		m_min    = zctm_pkg::RST_MIN;
		m_max    = zctm_pkg::RST_MAX;
		m_prev   = '0;
		m_armed  = 1'b0;
		m_start  = '0;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed rows at reset settings (offset 1800, noise 8, target 82.41 Hz)
		// first sample after reset sees a zero previous sample, so it arms at once
		add_row(12'd4095, 24'hFFFFFF, EXP_NONE, '0);
		add_row(12'd0, 24'h000000, EXP_NONE, '0);
		// 1e6 ticks: 100.00 Hz, in range, well sharp
		add_row(12'd4095, 24'd15777215, EXP_GIVEN,
			'{24'd1000000, 34'd10000, zctm_pkg::V_LOOSEN, 34'd1759});
		add_row(12'd0, 24'h123456, EXP_NONE, '0);
		add_row(12'd4095, 24'h000000, EXP_NONE, '0);
		add_row(12'd0, 24'hFFFFFF, EXP_NONE, '0);
		// one tick across the timer wrap: fastest frequency, out of range
		add_row(12'd4095, 24'hFFFFFF, EXP_GIVEN,
			'{24'd1, 34'd10000000000, zctm_pkg::V_RANGE, 34'd9999991759});
		add_row(12'd0, 24'h000100, EXP_NONE, '0);
		add_row(12'd4095, 24'h000100, EXP_NONE, '0);
		add_row(12'd0, 24'h000050, EXP_NONE, '0);
		// zero period: disarm, nothing out
		add_row(12'd4095, 24'h000100, EXP_NONE, '0);
		add_row(12'd0, 24'h000040, EXP_NONE, '0);
		add_row(12'd4095, 24'h000200, EXP_NONE, '0);
		// edges of the noise band
		add_row(12'd1792, 24'h000180, EXP_PREDICT, '0);
		add_row(12'd1808, 24'h000170, EXP_PREDICT, '0);
		add_row(12'd1792, 24'h000160, EXP_PREDICT, '0);
		add_row(12'd1809, 24'd15564284, EXP_PREDICT, '0);
		add_row(12'd1800, 24'h000000, EXP_PREDICT, '0);
		add_row(12'd1801, 24'hABCDEF, EXP_PREDICT, '0);
		add_row(12'd0, 24'h555555, EXP_PREDICT, '0);
		add_row(12'd2000, 24'h800000, EXP_PREDICT, '0);
		add_row(12'd1000, 24'h7AAAAA, EXP_PREDICT, '0);
		// 1.4e6 ticks: flat of target, in range
		add_row(12'd2000, 24'd6988608, EXP_PREDICT, '0);

		foreach (dir_rows[i])
			send_sample(dir_rows[i].smp, dir_rows[i].ts, dir_rows[i].kind, dir_rows[i].meas);

		// random phases, each with its own settings and pacing
		for (int ph = 0; ph < N_PHASES; ph++) begin
			gap_pct   = 0;
			stall_pct = 0;
			hold_off();
			load_settings(ph);
			case (ph % 4)
				1: gap_pct = 53;
				2: stall_pct = 53;
				3: begin
					gap_pct   = 35;
					stall_pct = 35;
				end
				default: ;
			endcase
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if ($urandom_range(0, 99) < 20) begin
					// noise, sometimes knocking the waveform out of step
					smp_v = zctm_pkg::SAMPLE_W'($urandom_range(0, 4095));
					ts_v  = zctm_pkg::TIME_W'($urandom);
					if ($urandom_range(0, 1) == 1)
						wave_hi = ~wave_hi;
				end else begin
					if (half_left == 0) begin
						wave_hi   = ~wave_hi;
						first_hi  = wave_hi;
						half_left = $urandom_range(1, 3);
					end
					half_left--;
					if (wave_hi) begin
						lo_b  = longint'(m_offset) + longint'(m_thr) + 1;
						smp_v = (lo_b > 4095) ? 12'd4095
							: zctm_pkg::SAMPLE_W'($urandom_range(lo_b, 4095));
					end else begin
						smp_v = zctm_pkg::SAMPLE_W'($urandom_range(0, m_offset));
					end
					if (first_hi) begin
						// crossing sample: pick the period since the last one
						pick = $urandom_range(0, 9);
						if (pick < 5) begin
							span = 2 * longint'(m_tol) + 50;
							fg = longint'(m_target) + longint'($urandom_range(0, 2 * span)) - span;
							if (fg < 1)
								fg = 1;
							per = CENTI_DIVIDEND / fg;
						end else if (pick < 7) begin
							if (longint'(m_max) > longint'(m_min) + 1)
								fg = $urandom_range(m_min + 1, m_max - 1);
							else
								fg = $urandom_range(1, 1000000);
							per = CENTI_DIVIDEND / fg;
						end else if (pick == 7) begin
							per = $urandom_range(1, 4096);
						end else if (pick == 8) begin
							per = longint'($urandom) & TIME_MAX;
						end else begin
							case ($urandom_range(0, 2))
								0: per = 0;
								1: per = 1;
								default: per = TIME_MAX;
							endcase
						end
						if (per > TIME_MAX)
							per = TIME_MAX;
						cross_ts = cross_ts - per[zctm_pkg::TIME_W-1:0];
						ts_v     = cross_ts;
						first_hi = 1'b0;
					end else begin
						ts_v = cross_ts - zctm_pkg::TIME_W'($urandom_range(0, 4000));
					end
				end
				send_sample(smp_v, ts_v, EXP_PREDICT, '0);
			end
		end

		hold_off();

		$display("Covered %0d samples: directed table, %0d random phases over extreme and random",
			n_accepted, N_PHASES);
		$display("register settings and four pacing modes; %0d results checked, %0d mismatches",
			n_checked, n_mismatch);
		if (n_mismatch == 0 && pending_meas.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
